>>> design/pfps_pkg.sv
`timescale 1ns / 1ps
package pfps_pkg;

  // Raster and frame store geometry
  localparam int STORE_WIDTH    = 384;
  localparam int STORE_HEIGHT   = 400;
  localparam int VISIBLE_WIDTH  = 320;
  localparam int VISIBLE_HEIGHT = 400;
  localparam int STORE_SIZE     = STORE_WIDTH * STORE_HEIGHT;

  // Four planes per pixel group, pixel groups spread over four banks
  localparam int NUM_PLANES = 4;
  localparam int NUM_BANKS  = 4;
  localparam int BANK_DEPTH = (STORE_SIZE + 15) / 16;
  localparam int ROW_W      = $clog2(BANK_DEPTH);

  // Linear scanout address before the wrap: below store size plus two store rows
  localparam int LIN_W = $clog2(STORE_SIZE + 2 * STORE_WIDTH);

  // Frame row before wrap reaches VISIBLE_HEIGHT - 1 + 512 - 1
  localparam int FROW_W     = 10;
  localparam int FROW_STEPS = (VISIBLE_HEIGHT + 512 - 1) / STORE_HEIGHT;
  localparam int COL_W      = 10;

  localparam int CMDQ_DEPTH = 4;
  localparam int OUTQ_DEPTH = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;

  typedef enum logic [1:0] {
    OP_PLANAR  = 2'd0,
    OP_PALETTE = 2'd1,
    OP_PIXEL   = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PLANE_MASK = 2'd0,
    REG_SPLIT_LINE = 2'd1,
    REG_HSCROLL    = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_FRAME   = 2'd0,
    CMD_PALETTE = 2'd1,
    CMD_PIXEL   = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] write_address;
    logic [31:0] write_data;
    logic [7:0]  palette_index;
    logic [7:0]  red_in;
    logic [7:0]  green_in;
    logic [7:0]  blue_in;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic       end_of_line;
    logic       end_of_frame;
  } out_t;

  typedef struct packed {
    logic [3:0]        plane_mask;
    logic signed [9:0] split_line;
    logic [6:0]        hscroll;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t                             kind;
    logic [NUM_BANKS-1:0][ROW_W-1:0]       row;
    logic [NUM_BANKS-1:0][NUM_PLANES-1:0]  be;
    logic [NUM_BANKS-1:0][7:0]             wbyte;
    logic [7:0]                            pal_idx;
    logic [23:0]                           pal_rgb;
    logic                                  blank;
    logic                                  eol;
    logic                                  eof;
    logic [FROW_W-1:0]                     frow;
    logic [COL_W-1:0]                      col;
  } cmd_t;

endpackage

>>> design/pfps_front.sv
`timescale 1ns / 1ps
module pfps_front import pfps_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_push,
  output logic in_full,
  input  in_t  in_data,
  input  cfg_t cfg,
  input  logic q_full,
  output logic q_push,
  output cmd_t q_cmd
);

  logic [8:0] col_r, col_nxt;
  logic [8:0] row_r, row_nxt;
  logic       accept;
  logic       eol;
  logic       eof;

  assign in_full = q_full;
  assign accept  = in_push && !q_full;
  assign eol     = col_r >= 9'(VISIBLE_WIDTH - 1);
  assign eof     = eol && (row_r >= 9'(VISIBLE_HEIGHT - 1));

  always_comb begin
    logic [1:0]        jsel;
    logic [16:0]       p;
    logic signed [10:0] y_s;
    logic signed [10:0] split_s;
    logic signed [10:0] frow_s;
    logic [FROW_W-1:0] frow_m;

    y_s     = $signed({2'b00, row_r});
    split_s = $signed({cfg.split_line[9], cfg.split_line});
    frow_s  = y_s - split_s - 11'sd1;
    // Fold the frame row back into the store
    frow_m  = frow_s[FROW_W-1:0];
    for (int s = 0; s < FROW_STEPS; s++) begin
      if (frow_m >= FROW_W'(STORE_HEIGHT)) begin
        frow_m = frow_m - FROW_W'(STORE_HEIGHT);
      end
    end

    q_cmd  = '0;
    q_push = 1'b0;
    unique case (in_data.opcode)
      OP_PLANAR: begin
        q_push     = accept;
        q_cmd.kind = CMD_FRAME;
        // Bank b takes the byte whose pixel group lands on it
        for (int b = 0; b < NUM_BANKS; b++) begin
          jsel = 2'(b) - in_data.write_address[1:0];
          p    = {1'b0, in_data.write_address} + 17'(jsel);
          q_cmd.row[b]   = ROW_W'(p >> 2);
          q_cmd.wbyte[b] = in_data.write_data[{jsel, 3'b000} +: 8];
          for (int k = 0; k < NUM_PLANES; k++) begin
            q_cmd.be[b][k] = cfg.plane_mask[k] && ({p, 2'(k)} < 19'(STORE_SIZE));
          end
        end
      end
      OP_PALETTE: begin
        q_push        = accept;
        q_cmd.kind    = CMD_PALETTE;
        q_cmd.pal_idx = in_data.palette_index;
        q_cmd.pal_rgb = {in_data.red_in, in_data.green_in, in_data.blue_in};
      end
      OP_PIXEL: begin
        q_push      = accept;
        q_cmd.kind  = CMD_PIXEL;
        q_cmd.eol   = eol;
        q_cmd.eof   = eof;
        q_cmd.blank = !(y_s > split_s);
        q_cmd.frow  = frow_m;
        q_cmd.col   = COL_W'(col_r) + COL_W'(cfg.hscroll);
      end
      default: begin
        q_push = 1'b0;
      end
    endcase
  end

  // Advance the raster on every accepted pixel request
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept && (in_data.opcode == OP_PIXEL)) begin
      if (eol) begin
        col_nxt = '0;
        row_nxt = eof ? 9'd0 : row_r + 9'd1;
      end else begin
        col_nxt = col_r + 9'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

endmodule

>>> design/pfps_cmdq.sv
`timescale 1ns / 1ps
module pfps_cmdq import pfps_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  localparam int PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t             mem_r [CMDQ_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full  = cnt_r == CNT_W'(CMDQ_DEPTH);
  assign empty = cnt_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

>>> design/pfps_back.sv
`timescale 1ns / 1ps
module pfps_back import pfps_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic q_empty,
  input  cmd_t q_head,
  output logic q_pop,
  input  logic out_pop,
  output logic out_empty,
  output out_t out_data
);

  localparam int OPTR_W = $clog2(OUTQ_DEPTH);
  localparam int OCNT_W = $clog2(OUTQ_DEPTH + 1);

  // Stage A: address known, frame store access
  logic             a_v_r;
  cmd_t             a_cmd_r;
  logic [LIN_W-1:0] a_lin_r;
  logic [LIN_W-1:0] lin_raw;
  logic [LIN_W-1:0] lin_mod;
  logic [ROW_W-1:0] a_rd_row;

  // Stage B: frame byte in hand, palette access
  logic                      b_v_r;
  cmd_kind_t                 b_kind_r;
  logic                      b_blank_r;
  logic                      b_eol_r;
  logic                      b_eof_r;
  logic [3:0]                b_lane_r;
  logic [7:0]                b_pal_idx_r;
  logic [23:0]               b_pal_rgb_r;
  logic [NUM_PLANES-1:0][7:0] bank_rd_r [NUM_BANKS];
  logic [7:0]                pix_byte;
  logic [23:0]               pal_mem [256];

  // Stage C: color in hand, into the result queue
  logic        c_v_r;
  logic        c_blank_r;
  logic        c_eol_r;
  logic        c_eof_r;
  logic [23:0] pal_rd_r;
  out_t        c_out;

  out_t              outq_r [OUTQ_DEPTH];
  logic [OPTR_W-1:0] owr_ptr_r, owr_ptr_nxt;
  logic [OPTR_W-1:0] ord_ptr_r, ord_ptr_nxt;
  logic [OCNT_W-1:0] ocnt_r, ocnt_nxt;
  logic              o_pop;
  logic [OCNT_W:0]   committed;

  // Hold pixel requests back unless the result queue has room for every pixel in flight
  assign committed = (OCNT_W + 1)'(ocnt_r)
                   + (OCNT_W + 1)'(a_v_r && (a_cmd_r.kind == CMD_PIXEL))
                   + (OCNT_W + 1)'(b_v_r && (b_kind_r == CMD_PIXEL))
                   + (OCNT_W + 1)'(c_v_r);
  assign q_pop = !q_empty &&
                 ((q_head.kind != CMD_PIXEL) || (committed < (OCNT_W + 1)'(OUTQ_DEPTH)));

  assign lin_raw = LIN_W'(q_head.frow) * LIN_W'(STORE_WIDTH) + LIN_W'(q_head.col);
  assign lin_mod = (lin_raw >= LIN_W'(STORE_SIZE)) ? lin_raw - LIN_W'(STORE_SIZE) : lin_raw;
  assign a_rd_row = ROW_W'(a_lin_r >> 4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      c_v_r <= 1'b0;
    end else begin
      a_v_r <= q_pop;
      b_v_r <= a_v_r;
      c_v_r <= b_v_r && (b_kind_r == CMD_PIXEL);
    end
  end

  always_ff @(posedge clk) begin
    a_cmd_r     <= q_head;
    a_lin_r     <= lin_mod;
    b_kind_r    <= a_cmd_r.kind;
    b_blank_r   <= a_cmd_r.blank;
    b_eol_r     <= a_cmd_r.eol;
    b_eof_r     <= a_cmd_r.eof;
    b_lane_r    <= a_lin_r[3:0];
    b_pal_idx_r <= a_cmd_r.pal_idx;
    b_pal_rgb_r <= a_cmd_r.pal_rgb;
    c_blank_r   <= b_blank_r;
    c_eol_r     <= b_eol_r;
    c_eof_r     <= b_eof_r;
  end

  // Frame store: one bank per pixel group modulo four, one byte lane per plane
  for (genvar gb = 0; gb < NUM_BANKS; gb++) begin : g_bank
    logic [NUM_PLANES-1:0][7:0] bank_mem [BANK_DEPTH];

    always_ff @(posedge clk) begin
      if (a_v_r && (a_cmd_r.kind == CMD_FRAME)) begin
        for (int k = 0; k < NUM_PLANES; k++) begin
          if (a_cmd_r.be[gb][k]) begin
            bank_mem[a_cmd_r.row[gb]][k] <= a_cmd_r.wbyte[gb];
          end
        end
      end
      if (a_v_r && (a_cmd_r.kind == CMD_PIXEL)) begin
        bank_rd_r[gb] <= bank_mem[a_rd_row];
      end
    end
  end

  assign pix_byte = bank_rd_r[b_lane_r[3:2]][b_lane_r[1:0]];

  // Palette write and read sit in the same stage so requests keep their order
  always_ff @(posedge clk) begin
    if (b_v_r && (b_kind_r == CMD_PALETTE)) begin
      pal_mem[b_pal_idx_r] <= b_pal_rgb_r;
    end
    if (b_v_r && (b_kind_r == CMD_PIXEL)) begin
      pal_rd_r <= pal_mem[pix_byte];
    end
  end

  always_comb begin
    c_out              = '0;
    c_out.end_of_line  = c_eol_r;
    c_out.end_of_frame = c_eof_r;
    if (!c_blank_r) begin
      c_out.pixel_red   = {pal_rd_r[21:16], 2'b00};
      c_out.pixel_green = {pal_rd_r[13:8], 2'b00};
      c_out.pixel_blue  = {pal_rd_r[5:0], 2'b00};
    end
  end

  // Result queue
  assign out_empty = ocnt_r == '0;
  assign out_data  = outq_r[ord_ptr_r];
  assign o_pop     = out_pop && !out_empty;

  always_comb begin
    owr_ptr_nxt = owr_ptr_r;
    ord_ptr_nxt = ord_ptr_r;
    ocnt_nxt    = ocnt_r;
    if (c_v_r) begin
      owr_ptr_nxt = (owr_ptr_r == OPTR_W'(OUTQ_DEPTH - 1)) ? '0 : owr_ptr_r + OPTR_W'(1);
    end
    if (o_pop) begin
      ord_ptr_nxt = (ord_ptr_r == OPTR_W'(OUTQ_DEPTH - 1)) ? '0 : ord_ptr_r + OPTR_W'(1);
    end
    if (c_v_r && !o_pop) begin
      ocnt_nxt = ocnt_r + OCNT_W'(1);
    end else if (o_pop && !c_v_r) begin
      ocnt_nxt = ocnt_r - OCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owr_ptr_r <= '0;
      ord_ptr_r <= '0;
      ocnt_r    <= '0;
    end else begin
      owr_ptr_r <= owr_ptr_nxt;
      ord_ptr_r <= ord_ptr_nxt;
      ocnt_r    <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (c_v_r) begin
      outq_r[owr_ptr_r] <= c_out;
    end
  end

endmodule

>>> design/planar_framebuffer_palette_scanout_core.sv
`timescale 1ns / 1ps
// Channel  | Ports                              | Request moves
// ---------+------------------------------------+------------------------------------
// input    | in_push, in_full, in_data          | planar write, palette write, pixel
// result   | out_empty, out_pop, out_data       | one pixel with line/frame marks
// config   | cfg_valid, cfg_ready, cfg_index,   | plane mask, split line, hscroll
//          | cfg_data                           |
//
// One request is accepted per cycle while the four-entry command queue has room.
// An accepted pixel passes through the command queue, the address stage, the frame bank
// read, the palette read and the result queue before it is ready on the result ports.
// Pixel requests leave the command queue only while the eight-entry result queue
// has room for them, so a stalled consumer backs up into in_full; writes ahead of a
// held pixel still drain.
// Reset is synchronous, active low; it clears the raster position, the registers
// and the queues. Frame store and palette are not cleared; no clearing pass runs.
module planar_framebuffer_palette_scanout_core import pfps_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  in_t                   in_data,
  output logic                  out_empty,
  input  logic                  out_pop,
  output out_t                  out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t cfg_r, cfg_nxt;

  logic q_push;
  cmd_t q_cmd;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_head;

  // Registers take a write in any cycle; software must write only while the block is idle, not enforced here
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_PLANE_MASK: cfg_nxt.plane_mask = cfg_data[3:0];
        REG_SPLIT_LINE: cfg_nxt.split_line = $signed(cfg_data);
        REG_HSCROLL:    cfg_nxt.hscroll    = cfg_data[6:0];
        default:        cfg_nxt = cfg_r;   // drop writes past the register list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: accept, track the raster, turn each request into a bank-level command
  pfps_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .cfg     (cfg_r),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_cmd   (q_cmd)
  );

  // Decouple the two halves so each stalls on its own
  pfps_cmdq u_cmdq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  // Back: run writes and lookups in request order, queue the pixels
  pfps_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule

>>> design/pfps_checker.sv
`timescale 1ns / 1ps
module pfps_checker import pfps_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_push,
  input logic                  in_full,
  input in_t                   in_data,
  input logic                  out_empty,
  input logic                  out_pop,
  input out_t                  out_data,
  input logic                  cfg_valid,
  input logic                  cfg_ready,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_data
);

  logic [7:0] pend_r, pend_nxt;
  logic       pix_in;
  logic       pix_out;

  assign pix_in  = in_push && !in_full && (in_data.opcode == OP_PIXEL);
  assign pix_out = out_pop && !out_empty;

  // Track pixel requests still owed a result
  always_comb begin
    pend_nxt = pend_r;
    if (pix_in && !pix_out) begin
      pend_nxt = pend_r + 8'd1;
    end else if (pix_out && !pix_in) begin
      pend_nxt = pend_r - 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("waiting result changed or vanished");

  a_frame_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.end_of_line || !out_data.end_of_frame))
    else $error("end of frame without end of line");

  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> pend_r != '0)
    else $error("result shown with no pixel request outstanding");

  // Take a register write in any cycle, with known index and data
  a_cfg_always_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready && !$isunknown({cfg_index, cfg_data}))
    else $error("config write refused or unknown");

endmodule

bind planar_framebuffer_palette_scanout_core pfps_checker u_pfps_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_push   (in_push),
  .in_full   (in_full),
  .in_data   (in_data),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data),
  .cfg_valid (cfg_valid),
  .cfg_ready (cfg_ready),
  .cfg_index (cfg_index),
  .cfg_data  (cfg_data)
);

>>> sim/tb_planar_framebuffer_palette_scanout_core.sv
`timescale 1ns / 1ps
module tb_planar_framebuffer_palette_scanout_core;
  import pfps_pkg::*;

  // Highest legal word offset of a planar write; its four pixel groups end on the last store byte.
  localparam int MAX_WORD = STORE_SIZE / NUM_PLANES - NUM_PLANES;
  // The block ignores this opcode.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Cycles to let the pipeline drain after the last pixel, with margin.
  localparam int DRAIN_CYCLES = 12;
  localparam int QUIET_LIMIT = 4000;
  localparam int LONG_HOLD = 400;
  localparam int MAX_REPORTS = 40;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_push = 1'b0;
  logic                  in_full;
  in_t                   in_data = '0;
  logic                  out_empty;
  logic                  out_pop = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  planar_framebuffer_palette_scanout_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Shadow display: register copies, frame store, color table and raster
  // position as they stand after every request the block has accepted.
  // ---------------------------------------------------------------------------
  logic [3:0]  mask_cfg = 4'h0;
  int          split_cfg = 0;
  int          hs_cfg = 0;
  logic [7:0]  frame_img [STORE_SIZE];
  logic [23:0] palette_img [256];
  int          ras_row = 0;
  int          ras_col = 0;
  out_t        pixels_due [$];
  int          mismatches = 0;

  // Layout of the stimulus: raster position after every queued request, and
  // which frame bytes and color entries are written once the queue drains.
  // Pixel requests are only queued when they read written entries.
  in_t         req_backlog [$];
  int          queued_row = 0;
  int          queued_col = 0;
  bit          frame_ok [STORE_SIZE];
  bit          pal_ok [256];
  logic [7:0]  pal_known [$];

  // Linear frame store address that pixel (row, col) reads, or -1 on a blanked row.
  function automatic int scan_addr(int row, int col);
    if (row <= split_cfg) return -1;
    return ((row - split_cfg - 1) * STORE_WIDTH + col + hs_cfg) % STORE_SIZE;
  endfunction

  // Advance row-major, wrap to the top after the last pixel of the frame.
  function automatic void raster_next(inout int row, inout int col);
    if (col + 1 >= VISIBLE_WIDTH) begin
      col = 0;
      row = (row + 1 >= VISIBLE_HEIGHT) ? 0 : row + 1;
    end else begin
      col++;
    end
  endfunction

  // Byte j of the word lands on every enabled plane; drop bytes past the store.
  // With layout_only set, only mark the bytes as written.
  function automatic void planar_write(logic [15:0] word, logic [31:0] data, bit layout_only);
    int where;
    for (int p = 0; p < NUM_PLANES; p++) begin
      if (mask_cfg[p]) begin
        for (int j = 0; j < 4; j++) begin
          where = p + (int'(word) + j) * NUM_PLANES;
          if (where < STORE_SIZE) begin
            if (layout_only) frame_ok[where] = 1'b1;
            else frame_img[where] = data[8*j +: 8];
          end
        end
      end
    end
  endfunction

  // Update the shadow display with one accepted request; queue the pixel it yields.
  function automatic void display_apply(in_t r);
    out_t       px;
    int         addr;
    logic [23:0] rgb;
    case (r.opcode)
      OP_PLANAR: planar_write(r.write_address, r.write_data, 1'b0);
      OP_PALETTE: palette_img[r.palette_index] = {r.red_in, r.green_in, r.blue_in};
      OP_PIXEL: begin
        px = '0;
        addr = scan_addr(ras_row, ras_col);
        if (addr >= 0) begin
          rgb = palette_img[frame_img[addr]];
          px.pixel_red   = {rgb[21:16], 2'b00};
          px.pixel_green = {rgb[13:8], 2'b00};
          px.pixel_blue  = {rgb[5:0], 2'b00};
        end
        px.end_of_line  = (ras_col + 1 >= VISIBLE_WIDTH);
        px.end_of_frame = px.end_of_line && (ras_row + 1 >= VISIBLE_HEIGHT);
        pixels_due.push_back(px);
        raster_next(ras_row, ras_col);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Request builders. Unused fields carry random values; planar data bytes are
  // drawn from color entries already written, so any pixel read of a written
  // frame byte also finds its color entry written.
  // ---------------------------------------------------------------------------
  function automatic in_t any_req();
    in_t r;
    r.opcode        = OP_UNUSED;
    r.write_address = 16'($urandom_range(0, MAX_WORD));
    r.write_data    = $urandom;
    r.palette_index = 8'($urandom);
    r.red_in        = 8'($urandom);
    r.green_in      = 8'($urandom);
    r.blue_in       = 8'($urandom);
    return r;
  endfunction

  function automatic void queue_req(in_t r);
    req_backlog.push_back(r);
    case (r.opcode)
      OP_PLANAR: planar_write(r.write_address, r.write_data, 1'b1);
      OP_PALETTE: begin
        if (!pal_ok[r.palette_index]) begin
          pal_ok[r.palette_index] = 1'b1;
          pal_known.push_back(r.palette_index);
        end
      end
      OP_PIXEL: raster_next(queued_row, queued_col);
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] pal_bytes();
    logic [31:0] d;
    for (int j = 0; j < 4; j++) d[8*j +: 8] = pal_known[$urandom_range(0, pal_known.size() - 1)];
    return d;
  endfunction

  function automatic void add_planar(int word, logic [31:0] data);
    in_t r;
    r = any_req();
    r.opcode        = OP_PLANAR;
    r.write_address = 16'(word);
    r.write_data    = data;
    queue_req(r);
  endfunction

  function automatic void add_palette(logic [7:0] idx, logic [23:0] rgb);
    in_t r;
    r = any_req();
    r.opcode        = OP_PALETTE;
    r.palette_index = idx;
    {r.red_in, r.green_in, r.blue_in} = rgb;
    queue_req(r);
  endfunction

  // Queue the next pixel, preceded by a planar write when it would read an
  // unwritten byte. Give up (return 0) when the plane mask cannot reach that byte.
  function automatic bit add_pixel();
    in_t r;
    int  addr;
    int  word;
    addr = scan_addr(queued_row, queued_col);
    if (addr >= 0 && !frame_ok[addr]) begin
      if (!mask_cfg[addr % NUM_PLANES]) return 1'b0;
      word = addr / NUM_PLANES;
      add_planar($urandom_range(word > 3 ? word - 3 : 0, word < MAX_WORD ? word : MAX_WORD),
                 pal_bytes());
    end
    r = any_req();
    r.opcode = OP_PIXEL;
    queue_req(r);
    return 1'b1;
  endfunction

  // Random mix of pixels, planar writes, palette writes and ignored opcodes.
  task automatic random_requests(int count, int pixel_pct);
    int done;
    int pick;
    done = 0;
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < pixel_pct && add_pixel()) begin
        done++;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          add_planar($urandom_range(0, MAX_WORD), pal_bytes());
          done++;
        end else if (pick < 92) begin
          add_palette(8'($urandom_range(0, 255)), 24'($urandom));
          done++;
        end else begin
          queue_req(any_req());
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Register writes, only while the block is idle.
  // ---------------------------------------------------------------------------
  task automatic write_reg(cfg_reg_t which, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= which;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (which)
      REG_PLANE_MASK: mask_cfg = val[3:0];
      REG_SPLIT_LINE: split_cfg = int'($signed(val));
      REG_HSCROLL:    hs_cfg = int'(val[6:0]);
      default: ;
    endcase
  endtask

  // Hold the sender until every pixel is back, then let the pipeline drain.
  task automatic settle();
    while (req_backlog.size() != 0 || pixels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(logic [3:0] mask, int split, int hs);
    settle();
    write_reg(REG_PLANE_MASK, {6'd0, mask});
    write_reg(REG_SPLIT_LINE, split[9:0]);
    write_reg(REG_HSCROLL, hs[9:0]);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of phases.
  // ---------------------------------------------------------------------------
  initial begin
    in_t req;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: color extremes, planar writes at the first and last word, the ignored opcode
    // with random fields and with all fields high but the address, then the first pixels of row 0.
    set_mode(4'hF, -1, 0);
    add_palette(8'h00, 24'h000000);
    add_palette(8'hFF, 24'hFFFFFF);
    add_palette(8'h55, 24'hAA55C3);
    add_palette(8'hAA, 24'h3C55AA);
    add_planar(0, 32'hAA55_00FF);
    add_planar(MAX_WORD, 32'h00FF_55AA);
    queue_req(any_req());
    req = '1;
    req.write_address = MAX_WORD;
    queue_req(req);
    repeat (10) void'(add_pixel());

    // Scroll to the end of the store row, whole image visible.
    set_mode(4'hF, -1, 64);
    random_requests(200, 60);

    // Partial plane masks and no plane at all: some pixels stay unreachable.
    set_mode(4'h5, 2, $urandom_range(0, 64));
    random_requests(150, 40);
    set_mode(4'h0, 0, 0);
    random_requests(100, 40);

    // Split far above the screen wraps frame rows through the store; a scroll
    // past the row end reads on into the next store row.
    set_mode(4'hF, -512, 127);
    random_requests(200, 60);

    set_mode(4'hA, int'($urandom_range(0, 4)) - 1, $urandom_range(0, 64));
    random_requests(200, 50);

    // Blank the whole screen and run the raster to the end of the current line.
    set_mode(4'($urandom_range(0, 15)), 399, $urandom_range(0, 64));
    do void'(add_pixel()); while (queued_col != 0);

    // Image back on from the top of the screen.
    set_mode(4'hF, -1, $urandom_range(0, 64));
    random_requests(200, 60);

    set_mode(4'($urandom_range(1, 15)), int'($urandom_range(0, 21)) - 1,
             $urandom_range(0, 64));
    random_requests(150, 50);

    settle();
    if (mismatches == 0) begin
      $display("planar_framebuffer_palette_scanout_core: match");
    end else begin
      $display("planar_framebuffer_palette_scanout_core: mismatch");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Driver: offer the backlog head in bursts of random length with random gaps.
  // Update the shadow display on each accepted request.
  // ---------------------------------------------------------------------------
  int burst_left = 8;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        display_apply(in_data);
        void'(req_backlog.pop_front());
      end
      if (gap_left > 0 || req_backlog.size() == 0) begin
        if (gap_left > 0) gap_left--;
        in_push <= 1'b0;
      end else begin
        in_push <= 1'b1;
        in_data <= req_backlog[0];
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 48);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: pop on a rotating stall pattern, compare each pixel with the
  // oldest one due. Twice, hold off long enough that in_full must rise.
  // ---------------------------------------------------------------------------
  int          pixels_seen = 0;
  int          hold_left = 0;
  int          pattern_left = 0;
  logic [15:0] pop_pattern = '1;

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t ns pixel %0d: %s got %0h, wanted %0h", $time, pixels_seen, what, got, want);
  endtask

  task automatic check_pixel(out_t got);
    out_t want;
    if (pixels_due.size() == 0) begin
      report_mismatch("pixel with none due", int'(got), 0);
      return;
    end
    want = pixels_due.pop_front();
    if (got.pixel_red !== want.pixel_red)
      report_mismatch("pixel_red", int'(got.pixel_red), int'(want.pixel_red));
    if (got.pixel_green !== want.pixel_green)
      report_mismatch("pixel_green", int'(got.pixel_green), int'(want.pixel_green));
    if (got.pixel_blue !== want.pixel_blue)
      report_mismatch("pixel_blue", int'(got.pixel_blue), int'(want.pixel_blue));
    if (got.end_of_line !== want.end_of_line)
      report_mismatch("end_of_line", int'(got.end_of_line), int'(want.end_of_line));
    if (got.end_of_frame !== want.end_of_frame)
      report_mismatch("end_of_frame", int'(got.end_of_frame), int'(want.end_of_frame));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        check_pixel(out_data);
        pixels_seen++;
        if (pixels_seen == 40 || pixels_seen == 600) hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pop_pattern = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
          pattern_left = 16;
        end
        out_pop <= pop_pattern[0];
        pop_pattern = {pop_pattern[0], pop_pattern[15:1]};
        pattern_left--;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run when no request, pixel or register write moves
  // for too long.
  // ---------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("planar_framebuffer_palette_scanout_core: mismatch");
      $finish;
    end
  end

endmodule
